// File: rtl/chc_pkg.sv
// ============================================================================
// chc_pkg - shared definitions for the character histogram coincidence core
// Action, status and register codes, fixed field widths and the divider
// status bundle.
// ============================================================================
package chc_pkg;

    // Default sizing
    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int COUNT_WIDTH_DEF   = 16;

    // Fixed field widths
    localparam int CHAR_W      = 8;
    localparam int ACTION_W    = 2;
    localparam int VALUE_W     = 17;   // Q1.16
    localparam int OUT_CNT_W   = 16;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int OUT_TDATA_W = 56;   // 51 payload bits padded to bytes

    // Input actions
    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd2;

    // Result kinds
    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FEW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVF = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_EN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_CHAR = 1'b1;

    // Divider status bundle
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// File: rtl/char_histogram_coincidence_core.sv
// ============================================================================
// char_histogram_coincidence_core - character histogram, index of coincidence
// Counts byte characters into a bin memory, keeps the length and the running
// sum of n(n-1) over all bins, answers frequency queries and coincidence
// reports in unsigned Q1.16.
//
// Channel   | Dir | Signals                        | Contents
// ----------+-----+--------------------------------+-----------------------------
// cfg       | in  | i_cfg_valid/o_cfg_ready        | index, 8-bit data
// s_axis    | in  | tvalid/tready/tdata/tuser      | char_code; action
// m_axis    | out | tvalid/tready/tdata/tuser      | value,counts,status; kind
//
// Adds: one per cycle while no query or report is in progress. The bin is
// read at the transfer and written back the next cycle; a back-to-back add to
// the same bin is forwarded from the write. Query: decode, divider load and 17
// steps, capture, output load; a report adds the n(n-1) multiply before the
// divider; with too few characters either goes straight to the output load.
// The input reopens as the result appears. Bins clear at once through per-bin
// valid flops; no sweep after reset. A waiting result does not stop adds; a
// query or report holds in its last state until the output register is free.
// ============================================================================
module char_histogram_coincidence_core
    import chc_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CHAR_W-1:0]      i_cfg_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] char_code
    input  logic [ACTION_W-1:0]    s_axis_tuser,   // [1:0] action
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [16:0] result_value,
                                                   // [32:17] char_count,
                                                   // [48:33] total_count,
                                                   // [50:49] status, rest 0
    output logic [0:0]             m_axis_tuser    // [0] result_kind
);

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int CW = COUNT_WIDTH;
    localparam int SW = 2 * COUNT_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic                   r_skip_en;
    logic [CHAR_W-1:0]      r_skip_char;

    t_state                 r_state;
    logic                   r_s2_valid;
    logic [ACTION_W-1:0]    r_s2_action;
    logic [AW-1:0]          r_s2_addr;
    logic                   r_s2_alpha;
    logic                   r_s2_skip;

    logic                   r_wr_valid;
    logic [AW-1:0]          r_wr_addr;
    logic [CW-1:0]          r_wr_data;

    logic [ALPHABET_SIZE-1:0] r_bin_valid;
    logic [CW-1:0]          r_length;
    logic [SW-1:0]          r_pair_sum;
    logic                   r_overflow;

    logic [SW-1:0]          r_div_num;
    logic [SW-1:0]          r_div_den;
    logic                   r_div_go;

    logic                   r_res_kind;
    logic [VALUE_W-1:0]     r_res_value;
    logic [CW-1:0]          r_res_cnt;
    logic [CW-1:0]          r_res_total;
    logic [STATUS_W-1:0]    r_res_status;

    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                   in_fire;
    logic                   in_alpha;
    logic                   in_skip;
    logic                   s2_hold;
    logic [CW-1:0]          ram_q;
    logic                   fwd_hit;
    logic [CW-1:0]          old_cnt;
    logic                   s2_add;
    logic                   len_full;
    logic                   do_write;
    logic                   s2_query;
    logic                   s2_report;
    logic [CW-1:0]          query_cnt;
    logic                   query_few;
    logic                   report_few;
    logic [STATUS_W-1:0]    ovf_status;
    logic                   out_free;
    logic [31:0]            res_cnt_ext;
    logic [31:0]            res_total_ext;
    t_div_sts               div_sts;
    logic [VALUE_W-1:0]     div_quot;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_en   <= 1'b0;
            r_skip_char <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SKIP_EN:   r_skip_en   <= i_cfg_data[0];
                REG_SKIP_CHAR: r_skip_char <= i_cfg_data;
                default:       r_skip_en   <= r_skip_en;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input acceptance and stage-1 decode
    // ------------------------------------------------------------------
    assign s2_hold       = r_s2_valid && (r_s2_action == ACT_QUERY ||
                                          r_s2_action == ACT_REPORT);
    assign s_axis_tready = (r_state == S_IDLE) && !s2_hold;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_alpha      = {1'b0, s_axis_tdata} < (CHAR_W + 1)'(ALPHABET_SIZE);
    assign in_skip       = r_skip_en && (s_axis_tdata == r_skip_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s2_action <= s_axis_tuser;
            r_s2_addr   <= s_axis_tdata[AW-1:0];
            r_s2_alpha  <= in_alpha;
            r_s2_skip   <= in_skip;
        end
    end

    // ------------------------------------------------------------------
    // Bin memory
    // ------------------------------------------------------------------
    chc_ram #(
        .WIDTH (CW),
        .DEPTH (ALPHABET_SIZE)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_s2_addr),
        .i_wdata (old_cnt + CW'(1)),
        .i_raddr (s_axis_tdata[AW-1:0]),
        .o_rdata (ram_q)
    );

    // ------------------------------------------------------------------
    // Stage 2: bin value with forwarding, add decision
    // ------------------------------------------------------------------
    always_comb begin
        fwd_hit    = r_wr_valid && (r_wr_addr == r_s2_addr);
        old_cnt    = fwd_hit ? r_wr_data :
                     (r_bin_valid[r_s2_addr] ? ram_q : '0);
        s2_add     = r_s2_valid && (r_s2_action == ACT_ADD) &&
                     r_s2_alpha && !r_s2_skip;
        len_full   = &r_length;
        do_write   = s2_add && !len_full;
        s2_query   = r_s2_valid && (r_s2_action == ACT_QUERY);
        s2_report  = r_s2_valid && (r_s2_action == ACT_REPORT);
        query_cnt  = r_s2_alpha ? old_cnt : '0;
        query_few  = (r_length == '0);
        report_few = (r_length[CW-1:1] == '0);
        ovf_status = r_overflow ? STAT_OVF : STAT_OK;
    end

    // Last write, kept for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else begin
            r_wr_valid <= do_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_wr_addr <= r_s2_addr;
            r_wr_data <= old_cnt + CW'(1);
        end
    end

    // Histogram totals and bin valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_valid <= '0;
            r_length    <= '0;
            r_pair_sum  <= '0;
            r_overflow  <= 1'b0;
        end else if (s2_report) begin
            r_bin_valid <= '0;
            r_length    <= '0;
            r_pair_sum  <= '0;
            r_overflow  <= 1'b0;
        end else if (do_write) begin
            r_bin_valid[r_s2_addr] <= 1'b1;
            r_length               <= r_length + CW'(1);
            r_pair_sum             <= r_pair_sum + SW'({old_cnt, 1'b0});
        end else if (s2_add) begin
            r_overflow <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Query / report sequencer
    // ------------------------------------------------------------------
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s2_query) begin
                        if (query_few) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state  <= S_DIV;
                            r_div_go <= 1'b1;
                        end
                    end else if (s2_report) begin
                        r_state <= report_few ? S_DONE : S_MUL;
                    end
                end
                S_MUL: begin
                    r_state  <= S_DIV;
                    r_div_go <= 1'b1;
                end
                S_DIV: begin
                    if (div_sts.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result fields and divider operands
    always_ff @(posedge i_clk) begin
        if (s2_query) begin
            r_res_kind   <= KIND_QUERY;
            r_res_cnt    <= query_cnt;
            r_res_total  <= r_length;
            r_res_status <= query_few ? STAT_FEW : ovf_status;
            r_res_value  <= '0;
            r_div_num    <= SW'(query_cnt);
            r_div_den    <= SW'(r_length);
        end else if (s2_report) begin
            r_res_kind   <= KIND_REPORT;
            r_res_cnt    <= '0;
            r_res_total  <= r_length;
            r_res_status <= report_few ? STAT_FEW : ovf_status;
            r_res_value  <= '0;
            r_div_num    <= r_pair_sum;
            r_div_den    <= SW'(r_length);
        end else if (r_state == S_MUL) begin
            r_div_den <= SW'(r_div_den[CW-1:0]) *
                         SW'(r_div_den[CW-1:0] - CW'(1));
        end else if (r_state == S_DIV && div_sts.done) begin
            r_res_value <= div_quot;
        end
    end

    chc_div #(
        .WIDTH (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_sts   (div_sts),
        .o_quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    assign res_cnt_ext   = 32'(r_res_cnt);
    assign res_total_ext = 32'(r_res_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_kind <= r_res_kind;
            r_out_data <= {5'b0, r_res_status, res_total_ext[OUT_CNT_W-1:0],
                           res_cnt_ext[OUT_CNT_W-1:0], r_res_value};
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_kind;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // no new item is taken while the divider runs
    a_ready_not_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !div_sts.busy)
        else $error("input ready while divider busy");

    // a report leaves the histogram totals cleared
    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_report |=> (r_length == '0 && r_pair_sum == '0 && !r_overflow))
        else $error("report did not clear state");

    // each counted add grows the length by exactly one
    a_add_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> (r_length == $past(r_length) + CW'(1)))
        else $error("length not incremented on add");

    // a result appears only out of the final sequencer state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");
`endif

endmodule

// File: rtl/chc_ram.sv
// ============================================================================
// chc_ram - generic single-port-write, single-port-read RAM
// One write port, one read port, read data registered.
// ============================================================================
module chc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/chc_div.sv
// ============================================================================
// chc_div - iterative restoring divider, Q1.16 quotient
// Produces num/den truncated to 17 bits, one quotient bit per cycle.
// Requires num <= den and den > 0.
// ============================================================================
module chc_div
    import chc_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [WIDTH-1:0]   i_num,
    input  logic [WIDTH-1:0]   i_den,
    output t_div_sts           o_sts,
    output logic [VALUE_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(VALUE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

    logic [WIDTH-1:0]   r_rem;
    logic [WIDTH-1:0]   r_den;
    logic [VALUE_W-1:0] r_quot;
    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic               r_first;
    logic               r_done;

    logic [WIDTH:0]     trial;
    logic [WIDTH:0]     diff;
    logic               ge;
    logic [WIDTH-1:0]   n_rem;

    // One restoring step: first step compares without shifting (integer bit)
    always_comb begin
        trial = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
            r_first <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_first <= 1'b1;
            end else if (r_busy) begin
                r_first <= 1'b0;
                r_step  <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[VALUE_W-2:0], ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule
